### rtl/core/ilt_pkg.sv
// ilt_pkg: types, codes and character classes for the INI line tokenizer.
// No dependencies; imported by ilt_fsm and ini_line_tokenizer.
package ilt_pkg;

    // Parser states; code 7 is unused and decodes as idle
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_SECTION = 3'd1,
        ST_KEY     = 3'd2,
        ST_KEY_SP  = 3'd3,
        ST_VALUE0  = 3'd4,
        ST_VALUE   = 3'd5,
        ST_COMMENT = 3'd6
    } state_t;

    // Event codes carried in event_kind
    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_SEC_OPEN  = 4'd1,
        EV_SEC_CHAR  = 4'd2,
        EV_SEC_CLOSE = 4'd3,
        EV_KEY_CHAR  = 4'd4,
        EV_KEY_CLOSE = 4'd5,
        EV_VAL_CHAR  = 4'd6,
        EV_VAL_CLOSE = 4'd7,
        EV_ERROR     = 4'd8
    } event_t;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;  // '['
    localparam logic [7:0] CH_RBRACKET = 8'h5D;  // ']'
    localparam logic [7:0] CH_EQUALS   = 8'h3D;  // '='
    localparam logic [7:0] CH_HASH     = 8'h23;  // '#'
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;  // '\n'

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [7:0] char_out;
    } out_item_t;

    // C locale: tab..carriage return and space
    function automatic logic is_ws(input logic [7:0] c);
        return (c inside {[8'd9:8'd13], 8'd32});
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

endpackage

### rtl/core/ilt_fsm.sv
// ilt_fsm: parser state register and per-character event decode.
// Depends on ilt_pkg.
module ilt_fsm
    import ilt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_item_t  item,
    output out_item_t result
);

    state_t     state_reg;
    state_t     state_next;
    event_t     ev;
    logic [7:0] co;
    logic [7:0] c;

    assign c = item.char_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ev         = EV_NONE;
        co         = '0;
        if (item.end_of_input) begin
            case (state_reg)
                ST_SECTION, ST_KEY, ST_KEY_SP: begin
                    ev = EV_ERROR;
                end
                ST_VALUE0, ST_VALUE: begin
                    ev = EV_VAL_CLOSE;
                end
                default: begin
                    ev = EV_NONE;
                end
            endcase
            state_next = ST_IDLE;
        end else begin
            case (state_reg)
                ST_SECTION: begin
                    if (c == CH_RBRACKET) begin
                        ev         = EV_SEC_CLOSE;
                        state_next = ST_IDLE;
                    end else begin
                        ev = EV_SEC_CHAR;
                        co = c;
                    end
                end
                ST_KEY: begin
                    if (c == CH_EQUALS) begin
                        ev         = EV_KEY_CLOSE;
                        state_next = ST_VALUE0;
                    end else if (is_ws(c)) begin
                        ev         = EV_KEY_CLOSE;
                        state_next = ST_KEY_SP;
                    end else begin
                        ev = EV_KEY_CHAR;
                        co = c;
                    end
                end
                ST_KEY_SP: begin
                    if (c == CH_EQUALS) begin
                        state_next = ST_VALUE0;
                    end else if (!is_ws(c)) begin
                        ev = EV_ERROR;
                    end
                end
                ST_VALUE0: begin
                    if (c == CH_NEWLINE) begin
                        ev         = EV_VAL_CLOSE;
                        state_next = ST_IDLE;
                    end else if (!is_ws(c)) begin
                        ev         = EV_VAL_CHAR;
                        co         = c;
                        state_next = ST_VALUE;
                    end
                end
                ST_VALUE: begin
                    if (c == CH_NEWLINE) begin
                        ev         = EV_VAL_CLOSE;
                        state_next = ST_IDLE;
                    end else begin
                        ev = EV_VAL_CHAR;
                        co = c;
                    end
                end
                ST_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        state_next = ST_IDLE;
                    end
                end
                default: begin
                    // idle, and the unused code behaves as idle
                    if (c == CH_LBRACKET) begin
                        ev         = EV_SEC_OPEN;
                        state_next = ST_SECTION;
                    end else if (is_alnum(c)) begin
                        ev         = EV_KEY_CHAR;
                        co         = c;
                        state_next = ST_KEY;
                    end else if (c == CH_HASH) begin
                        state_next = ST_COMMENT;
                    end else if (!is_ws(c)) begin
                        ev         = EV_ERROR;
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign result.event_kind = ev;
    assign result.char_out   = co;

endmodule

### rtl/core/ini_line_tokenizer.sv
// ini_line_tokenizer: top level of the character-serial INI tokenizer.
// Depends on ilt_pkg and ilt_fsm.
//
// Usage
//   s_ channel: one text byte per transaction (s_data.char_in), or an
//     end-of-input marker (s_data.end_of_input = 1) that flushes a pending
//     value, or flags an unfinished section/key, and returns to idle.
//   m_ channel: exactly one event per input transaction, in order
//     (m_data.event_kind, m_data.char_out; char_out is zero unless the
//     event carries a character).
//   Path: an item taken into the input register is decoded from it and
//     lands in the result register once that is free; m_valid is high after it.
//   Throughput: one transaction per cycle while m_ready is high, set by
//     the combinational decode and the one-step state update.
//   Stall: when m_ready is low the result register holds; the input
//     register still takes one more item, then s_ready drops until the
//     result drains.
//   Reset (aresetn low, synchronous): both stages empty, parser idle.
module ini_line_tokenizer
    import ilt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // input stage
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    // result stage
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      out_free;   // result register can take a transaction
    logic      advance;    // input stage moves to result stage
    out_item_t decoded;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Parser state advances only when its item's event is committed
    ilt_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .result  (decoded)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= decoded;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // Both stages full and stalled: no room for another transaction
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted with both stages full");

    // Only character events carry a character
    a_char_only_on_char_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.char_out != 8'd0) |->
            (m_data.event_kind == EV_SEC_CHAR) || (m_data.event_kind == EV_KEY_CHAR) ||
            (m_data.event_kind == EV_VAL_CHAR))
        else $error("char_out set on a non-character event");

    // Event code stays in the defined range
    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.event_kind <= EV_ERROR))
        else $error("undefined event code");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule
